### src/bspc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bspc_pkg: shared types and constants
// Operation and status codes, result layout and memory control for the
// bounded stack with palindrome check.
// ----------------------------------------------------------------------------
package bspc_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned DEFAULT_DEPTH = 8;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PAL  = 2'd2,
    OP_DUMP = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef struct packed {
    status_e                   status;
    logic signed [DATA_W-1:0]  data;
    logic                      pal;
    logic                      last;
  } result_t;

  // Strobes from the sequencer to the stack memory.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage
`default_nettype wire

### src/bspc_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bspc_mem: stack storage
// One write port and two read ports with registered read data. Read data
// holds while no read is requested.
// ----------------------------------------------------------------------------
module bspc_mem
  import bspc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DEFAULT_DEPTH,
  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire mem_ctl_t          ctl_i,
  input  wire logic [AW-1:0]     wr_addr_i,
  input  wire logic [DATA_W-1:0] wr_data_i,
  input  wire logic [AW-1:0]     rd_addr_a_i,
  input  wire logic [AW-1:0]     rd_addr_b_i,
  output logic      [DATA_W-1:0] rd_data_a_o,
  output logic      [DATA_W-1:0] rd_data_b_o
);

  logic [DATA_W-1:0] mem_q [STACK_DEPTH];

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_data_a_o <= mem_q[rd_addr_a_i];
      rd_data_b_o <= mem_q[rd_addr_b_i];
    end
  end

endmodule
`default_nettype wire

### src/bounded_stack_with_palindrome_check.sv
`default_nettype none
// Push and every error result are registered at the request edge and
//   appear the next cycle; pop reads the memory first, then registers the word.
// Palindrome check: each pair is read in S_PAL_RD and compared in S_PAL_CMP
//   on the memory's two read ports; a mismatching pair ends it early.
// Read-out: one memory read per entry in S_DUMP_RD, then S_DUMP_OUT, plus stalls.
// One request at a time, taken as the last result leaves; async reset empties it.
// ----------------------------------------------------------------------------
// bounded_stack_with_palindrome_check: LIFO stack with palindrome check
// Sequencer over a two-read-port stack memory; results leave through an
// output register.
// ----------------------------------------------------------------------------
module bounded_stack_with_palindrome_check
  import bspc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DEFAULT_DEPTH
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [1:0]               operation_i,
  input  wire logic signed [DATA_W-1:0] push_value_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [1:0]                    status_o,
  output logic signed [DATA_W-1:0]      data_word_o,
  output logic                          is_palindrome_o,
  output logic                          last_o
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_PAL_RD,
    S_PAL_CMP,
    S_DUMP_RD,
    S_DUMP_OUT
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [AW-1:0]     i_q, i_d;
  logic [AW-1:0]     j_q, j_d;
  result_t           res_q, res_d;
  logic              out_valid_q, out_valid_d;

  mem_ctl_t          mem_ctl;
  logic [AW-1:0]     rd_addr_a;
  logic [DATA_W-1:0] rd_data_a, rd_data_b;

  logic              out_free;
  logic              in_accept;
  logic [CW-1:0]     cnt_m1;
  logic              is_full, is_empty, dump_last;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign cnt_m1     = cnt_q - 1'b1;
  assign is_full    = (cnt_q == CW'(STACK_DEPTH));
  assign is_empty   = (cnt_q == '0);
  assign dump_last  = (i_q == cnt_m1[AW-1:0]);

  bspc_mem #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_mem (
    .clk_i      (clk_i),
    .ctl_i      (mem_ctl),
    .wr_addr_i  (cnt_q[AW-1:0]),
    .wr_data_i  (push_value_i),
    .rd_addr_a_i(rd_addr_a),
    .rd_addr_b_i(j_q),
    .rd_data_a_o(rd_data_a),
    .rd_data_b_o(rd_data_b)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    i_d         = i_q;
    j_d         = j_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_ctl     = '0;
    rd_addr_a   = i_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          res_d = '{status: ST_OK, data: '0, pal: 1'b0, last: 1'b1};
          unique case (op_e'(operation_i))
            OP_PUSH: begin
              out_valid_d = 1'b1;
              if (is_full) begin
                res_d.status = ST_OVERFLOW;
              end else begin
                mem_ctl.wr_en = 1'b1;
                cnt_d         = cnt_q + 1'b1;
              end
            end
            OP_POP: begin
              if (is_empty) begin
                out_valid_d  = 1'b1;
                res_d.status = ST_UNDERFLOW;
              end else begin
                mem_ctl.rd_en = 1'b1;
                rd_addr_a     = cnt_m1[AW-1:0];
                cnt_d         = cnt_m1;
                state_d       = S_POP;
              end
            end
            OP_PAL: begin
              if (is_empty) begin
                out_valid_d  = 1'b1;
                res_d.status = ST_EMPTY;
              end else begin
                i_d     = '0;
                j_d     = cnt_m1[AW-1:0];
                state_d = S_PAL_RD;
              end
            end
            OP_DUMP: begin
              if (is_empty) begin
                out_valid_d  = 1'b1;
                res_d.status = ST_EMPTY;
              end else begin
                i_d     = '0;
                state_d = S_DUMP_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          res_d       = '{status: ST_OK, data: rd_data_a, pal: 1'b0, last: 1'b1};
          state_d     = S_IDLE;
        end
      end
      S_PAL_RD: begin
        if (i_q < j_q) begin
          mem_ctl.rd_en = 1'b1;
          state_d       = S_PAL_CMP;
        end else if (out_free) begin
          // pointers met: every pair matched
          out_valid_d = 1'b1;
          res_d       = '{status: ST_OK, data: '0, pal: 1'b1, last: 1'b1};
          state_d     = S_IDLE;
        end
      end
      S_PAL_CMP: begin
        if (rd_data_a != rd_data_b) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            res_d       = '{status: ST_OK, data: '0, pal: 1'b0, last: 1'b1};
            state_d     = S_IDLE;
          end
        end else begin
          i_d     = i_q + 1'b1;
          j_d     = j_q - 1'b1;
          state_d = S_PAL_RD;
        end
      end
      S_DUMP_RD: begin
        mem_ctl.rd_en = 1'b1;
        state_d       = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          res_d       = '{status: ST_OK, data: rd_data_a, pal: 1'b0, last: dump_last};
          if (dump_last) begin
            state_d = S_IDLE;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = S_DUMP_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      i_q         <= i_d;
      j_q         <= j_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = res_q.status;
  assign data_word_o     = res_q.data;
  assign is_palindrome_o = res_q.pal;
  assign last_o          = res_q.last;

endmodule
`default_nettype wire
